// File: rtl/vwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vwt_pkg;

    localparam int COORD_BITS  = 32;
    localparam int ENTRY_W     = 3 * COORD_BITS;
    localparam int LIMIT_W     = 16;
    localparam int INDEX_W     = 10;
    localparam int TOTAL_W     = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd11;

    localparam logic ACT_WELD  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } vwt_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               table_full;
        logic [TOTAL_W-1:0] vertex_total;
    } vwt_out_t;

endpackage

`default_nettype wire

// File: rtl/vwt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vwt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/vertex_weld_table.sv
// a clear gives its result without reading the table; a weld reads the stored vertices
// in order from entry 0 and stops at the first match or after the last one (at once if empty)
// one item in flight, the next accepted only once the block is idle again after the result;
// entries are scanned by the single three-axis compare unit reading one entry per cycle
// reset: vertex count cleared, match_limit back to 11; ram contents are not cleared,
// entries at or above the count are never read
`timescale 1ns / 1ps
`default_nettype none

module vertex_weld_table
    import vwt_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_data,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire vwt_in_t            req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output vwt_out_t                rsp
);

    localparam int IDX_W     = $clog2(MAX_VERTICES);
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
    localparam int IDX_OUT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int CNT_OUT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t             state_reg, state_next;
    vwt_in_t            item_reg, item_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;
    vwt_out_t           rsp_reg, rsp_next;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_we;
    logic               ram_re;

    logic [COORD_BITS-1:0] ent_x, ent_y, ent_z;
    logic [COORD_BITS:0]   dist_x, dist_y, dist_z;
    logic [COORD_BITS:0]   limit_ext;
    logic                  hit;
    logic                  is_clear;
    logic                  scan_done;
    logic                  finish;
    logic                  out_free;
    logic                  has_space;
    logic                  accept;
    logic [IDX_W-1:0]      res_idx;
    logic [IDX_OUT_W-1:0]  res_idx_wide;
    logic [CNT_OUT_W-1:0]  res_cnt_wide;

    function automatic logic [COORD_BITS:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[COORD_BITS] ? (~d + 1'b1) : d;
    endfunction

    vwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // compare unit: one stored entry against the held vertex, all three axes
    always_comb
    begin
        ent_x     = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
        ent_y     = ram_rdata[2*COORD_BITS-1:COORD_BITS];
        ent_z     = ram_rdata[COORD_BITS-1:0];
        limit_ext = (COORD_BITS + 1)'(limit_reg);
        dist_x    = abs_diff(item_reg.coord_x, ent_x);
        dist_y    = abs_diff(item_reg.coord_y, ent_y);
        dist_z    = abs_diff(item_reg.coord_z, ent_z);
        hit       = (dist_x < limit_ext) && (dist_y < limit_ext) && (dist_z < limit_ext);
    end

    assign ram_wdata = {item_reg.coord_x, item_reg.coord_y, item_reg.coord_z};
    assign is_clear  = (item_reg.action == ACT_CLEAR);
    assign has_space = (count_reg < CNT_MAX);
    assign scan_done = pend_reg ? hit : (rd_ptr_reg >= count_reg);
    assign finish    = (state_reg == ST_SCAN) && (is_clear || scan_done);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ram_re    = (state_reg == ST_SCAN) && !finish && (rd_ptr_reg < count_reg);
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        res_idx        = '0;
        res_idx_wide   = '0;
        res_cnt_wide   = '0;

        if (cfg_we)
        begin
            limit_next = cfg_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next   = req;
                    rd_ptr_next = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    if (out_free)
                    begin
                        rsp_next.is_new     = 1'b0;
                        rsp_next.table_full = 1'b0;
                        if (is_clear)
                        begin
                            count_next = '0;
                        end
                        else if (pend_reg && hit)
                        begin
                            res_idx = pend_idx_reg;
                        end
                        else if (has_space)
                        begin
                            res_idx         = count_reg[IDX_W-1:0];
                            ram_we          = 1'b1;
                            count_next      = count_reg + 1'b1;
                            rsp_next.is_new = 1'b1;
                        end
                        else
                        begin
                            rsp_next.table_full = 1'b1;
                        end
                        res_idx_wide          = IDX_OUT_W'(res_idx);
                        res_cnt_wide          = CNT_OUT_W'(count_next);
                        rsp_next.vertex_index = res_idx_wide[INDEX_W-1:0];
                        rsp_next.vertex_total = res_cnt_wide[TOTAL_W-1:0];
                        rsp_valid_next        = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
                else
                begin
                    // read issued now is compared on the next cycle
                    pend_next     = ram_re;
                    pend_idx_next = rd_ptr_reg[IDX_W-1:0];
                    if (ram_re)
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pend_idx_reg <= pend_idx_next;
        rsp_reg      <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("vertex count above table depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_ptr_reg <= count_reg))
        else $error("scan pointer ran past stored entries");

    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.is_new) |-> !rsp_reg.table_full)
        else $error("result both new and full");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.table_full) |-> (count_reg == CNT_MAX))
        else $error("full reported with free entries");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && out_free && !is_clear && !(pend_reg && hit) && has_space)
        |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("append did not bump the vertex count");

endmodule

`default_nettype wire

// File: dv/vertex_weld_checker.sv
`timescale 1ns / 1ps

module vertex_weld_checker
    import vwt_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               req_valid,
    input  logic               req_stall,
    input  vwt_in_t            req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  vwt_out_t           rsp,
    output int                 mismatch_count,
    output int                 results_pending,
    output int                 appended,
    output int                 matched,
    output int                 dropped,
    output int                 clears
);

    // shadow copy of the vertex table and the match limit
    logic signed [COORD_BITS-1:0] shadow_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] shadow_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] shadow_z [MAX_VERTICES];
    int unsigned                  shadow_total;
    logic [LIMIT_W-1:0]           tolerance;
    vwt_out_t                     welds_due [$];

    // exact difference, no wrap at the coordinate extremes
    function automatic bit axis_close(logic signed [COORD_BITS-1:0] a,
                                      logic signed [COORD_BITS-1:0] b);
        longint gap;
        gap = longint'(a) - longint'(b);
        if (gap < 0)
            gap = -gap;
        return gap < longint'(tolerance);
    endfunction

    function automatic vwt_out_t weld_predict(vwt_in_t item);
        vwt_out_t res;
        bit       hit;
        res = '0;
        hit = 1'b0;
        if (item.action == ACT_CLEAR) begin
            shadow_total = 0;
        end
        else begin
            // first stored vertex within the limit on all three axes wins
            for (int k = 0; k < shadow_total && !hit; k++) begin
                if (axis_close(item.coord_x, shadow_x[k]) &&
                    axis_close(item.coord_y, shadow_y[k]) &&
                    axis_close(item.coord_z, shadow_z[k]))
                begin
                    res.vertex_index = INDEX_W'(k);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (shadow_total < MAX_VERTICES) begin
                    shadow_x[shadow_total] = item.coord_x;
                    shadow_y[shadow_total] = item.coord_y;
                    shadow_z[shadow_total] = item.coord_z;
                    res.vertex_index = INDEX_W'(shadow_total);
                    res.is_new = 1'b1;
                    shadow_total++;
                end
                else begin
                    res.table_full = 1'b1;
                end
            end
        end
        res.vertex_total = TOTAL_W'(shadow_total);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        vwt_out_t due;
        if (!rst_n) begin
            tolerance = LIMIT_RESET;
            shadow_total = 0;
            welds_due.delete();
            mismatch_count = 0;
            results_pending = 0;
            appended = 0;
            matched = 0;
            dropped = 0;
            clears = 0;
        end
        else begin
            if (cfg_we)
                tolerance = cfg_data;
            if (req_valid && !req_stall) begin
                due = weld_predict(req);
                welds_due.insert(welds_due.size(), due);
                if (req.action == ACT_CLEAR)
                    clears++;
                else if (due.is_new)
                    appended++;
                else if (due.table_full)
                    dropped++;
                else
                    matched++;
            end
            if (rsp_valid && !rsp_stall) begin
                if (welds_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: response transaction with nothing outstanding:"
                                 , $time, " index %0d new %0b full %0b total %0d",
                                 rsp.vertex_index, rsp.is_new, rsp.table_full,
                                 rsp.vertex_total);
                end
                else begin
                    due = welds_due.pop_front();
                    if (rsp.vertex_index !== due.vertex_index ||
                        rsp.is_new !== due.is_new ||
                        rsp.table_full !== due.table_full ||
                        rsp.vertex_total !== due.vertex_total)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch, expected index %0d new %0b full %0b",
                                     $time, due.vertex_index, due.is_new, due.table_full,
                                     " total %0d, got index %0d new %0b full %0b total %0d",
                                     due.vertex_total, rsp.vertex_index, rsp.is_new,
                                     rsp.table_full, rsp.vertex_total);
                    end
                end
            end
            results_pending = welds_due.size();
        end
    end

endmodule

// File: dv/vertex_weld_table_test.sv
`timescale 1ns / 1ps

module vertex_weld_table_test;
    import vwt_pkg::*;

    localparam int MAX_VERTICES = 1024;
    localparam int IDLE_LIMIT   = 8000;
    localparam int PHASE_ITEMS  = 97;
    localparam int HOLD_CYCLES  = 400;

    localparam logic signed [COORD_BITS-1:0] C_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_BITS-1:0] C_MIN = 32'sh8000_0000;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    vwt_in_t            req = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    vwt_out_t           rsp;

    int mismatch_count;
    int results_pending;
    int appended;
    int matched;
    int dropped;
    int clears;

    int       cur_limit = LIMIT_RESET;
    int       burst_left = 0;
    int       hold_asks = 0;
    int       holds_done = 0;
    int       idle_cycles = 0;
    vwt_in_t  recent [$];

    always #5 clk = ~clk;

    vertex_weld_table #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    vertex_weld_checker #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .results_pending(results_pending),
        .appended       (appended),
        .matched        (matched),
        .dropped        (dropped),
        .clears         (clears)
    );

    // receiver: switches between free running, random and periodic stalls,
    // and holds off for a long stretch whenever the stimulus asks for it
    rx_mode_t rx_mode = RX_FREE;
    int       mode_left = 0;
    int       stall_pct = 0;
    int       period = 1;
    int       duty = 0;
    int       rx_cycle = 0;
    int       hold_cycles = 0;

    always @(negedge clk) begin
        if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
        end
        else if (holds_done != hold_asks) begin
            rsp_stall <= 1'b1;
            holds_done++;
            hold_cycles = HOLD_CYCLES;
        end
        else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 300);
                stall_pct = $urandom_range(10, 80);
                period = $urandom_range(2, 12);
                duty = $urandom_range(1, period - 1);
            end
            mode_left--;
            rx_cycle++;
            case (rx_mode)
                RX_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < stall_pct);
                RX_PERIODIC: rsp_stall <= ((rx_cycle % period) < duty);
                default:     rsp_stall <= 1'b0;
            endcase
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic vwt_in_t make_item(logic act, logic signed [COORD_BITS-1:0] x,
                                          logic signed [COORD_BITS-1:0] y,
                                          logic signed [COORD_BITS-1:0] z);
        vwt_in_t item;
        item.action = act;
        item.coord_x = x;
        item.coord_y = y;
        item.coord_z = z;
        return item;
    endfunction

    // move a coordinate around the match limit, either strictly inside or
    // on and around the boundary
    function automatic logic signed [COORD_BITS-1:0] nudge(
        logic signed [COORD_BITS-1:0] c, bit inside_only);
        int d;
        int span;
        span = cur_limit + 2;
        if (inside_only) begin
            if (cur_limit == 0)
                d = 0;
            else
                d = int'($urandom_range(0, 2 * (cur_limit - 1))) - (cur_limit - 1);
        end
        else begin
            case ($urandom_range(0, 4))
                0:       d = cur_limit;
                1:       d = -cur_limit;
                2:       d = cur_limit - 1;
                3:       d = 1 - cur_limit;
                default: d = int'($urandom_range(0, 2 * span)) - span;
            endcase
        end
        return c + d;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 6))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return C_MIN + $urandom_range(0, 16);
            default: return C_MAX - $urandom_range(0, 16);
        endcase
    endfunction

    function automatic vwt_in_t random_item();
        int      pick;
        int      r;
        bit      inside_only;
        vwt_in_t base;
        pick = $urandom_range(0, 99);
        r = 2 * cur_limit + 4;
        if (pick < 4)
            return make_item(ACT_CLEAR, $urandom, $urandom, $urandom);
        if (pick < 55 && recent.size() != 0) begin
            // revisit a recent vertex so that matches are common
            base = recent[$urandom_range(0, recent.size() - 1)];
            inside_only = $urandom_range(0, 1);
            return make_item(ACT_WELD, nudge(base.coord_x, inside_only),
                             nudge(base.coord_y, inside_only),
                             nudge(base.coord_z, inside_only));
        end
        if (pick < 75)
            return make_item(ACT_WELD, $urandom, $urandom, $urandom);
        if (pick < 87)
            return make_item(ACT_WELD, extreme_coord(), extreme_coord(), extreme_coord());
        return make_item(ACT_WELD, int'($urandom_range(0, 2 * r)) - r,
                         int'($urandom_range(0, 2 * r)) - r,
                         int'($urandom_range(0, 2 * r)) - r);
    endfunction

    task automatic send(vwt_in_t item);
        int gap;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        if (item.action == ACT_WELD) begin
            recent.insert(recent.size(), item);
            if (recent.size() > 64)
                void'(recent.pop_front());
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // stop offering and wait for every outstanding transaction to come back
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(int value);
        settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= LIMIT_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_limit = value;
    endtask

    initial begin
        int value;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed part at the reset limit
        send(make_item(ACT_WELD, 0, 0, 0));
        send(make_item(ACT_WELD, 10, -10, 10));
        send(make_item(ACT_WELD, 11, 0, 0));
        send(make_item(ACT_WELD, 0, -11, 0));
        send(make_item(ACT_WELD, C_MAX, C_MAX, C_MAX));
        send(make_item(ACT_WELD, C_MIN, C_MIN, C_MIN));
        send(make_item(ACT_WELD, C_MAX - 10, C_MAX, C_MAX - 10));
        send(make_item(ACT_WELD, C_MIN + 10, C_MIN, C_MIN + 1));
        send(make_item(ACT_WELD, C_MAX, C_MIN, 0));
        send(make_item(ACT_WELD, -1, -1, -1));
        // two stored vertices both in range, the earlier one must win
        send(make_item(ACT_WELD, 100, 0, 0));
        send(make_item(ACT_WELD, 115, 0, 0));
        send(make_item(ACT_WELD, 108, 0, 0));
        send(make_item(ACT_CLEAR, 32'sh5555_5555, 32'shaaaa_aaaa, -1));
        send(make_item(ACT_CLEAR, 0, 0, 0));
        send(make_item(ACT_WELD, 32'sh5555_5555, 32'shaaaa_aaaa, C_MIN));
        send(make_item(ACT_WELD, 32'shaaaa_aaaa, 32'sh5555_5555, C_MAX));
        write_limit(0);
        send(make_item(ACT_WELD, 7, 7, 7));
        send(make_item(ACT_WELD, 7, 7, 7));
        write_limit(65535);
        send(make_item(ACT_WELD, 7 + 65534, 7 - 65534, 7));
        send(make_item(ACT_WELD, 7 + 65535, 7, 7));
        send(make_item(ACT_CLEAR, 0, 0, 0));

        // fill the whole table, then hit it with matches and misses
        write_limit(0);
        for (int k = 0; k < MAX_VERTICES; k++)
            send(make_item(ACT_WELD, k << 20, ~(k << 20), k * 3));
        send(make_item(ACT_WELD, 0, 0, 0));
        write_limit(1);
        send(make_item(ACT_WELD, (MAX_VERTICES - 1) << 20, ~((MAX_VERTICES - 1) << 20),
                       (MAX_VERTICES - 1) * 3));
        send(make_item(ACT_WELD, 512 << 20, ~(512 << 20), 512 * 3));
        send(make_item(ACT_WELD, C_MAX, C_MAX, C_MAX));
        send(make_item(ACT_CLEAR, 0, 0, 0));

        // random phases, each under its own match limit
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       value = 65535;
                1:       value = 1;
                2:       value = $urandom_range(2, 64);
                3:       value = LIMIT_RESET;
                4:       value = $urandom_range(0, 65535);
                default: value = $urandom_range(100, 4000);
            endcase
            write_limit(value);
            if (p == 1 || p == 4)
                hold_asks++;
            repeat (PHASE_ITEMS)
                send(random_item());
        end

        settle();
        repeat (20) @(negedge clk);
        $display("%0d transactions: %0d vertices appended, %0d matched, %0d refused full,",
                 appended + matched + dropped + clears, appended, matched, dropped,
                 " %0d clears", clears);
        $display("limits 0, 1, 11, 65535 and random ones; %0d long receiver hold-offs",
                 holds_done);
        if (mismatch_count == 0 && results_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
